// ===== design/eos_pkg.sv =====
// shared constants and control types for the ellipse outline stepper
package eos_pkg;

  localparam int COORD_BITS_DEF = 12;

  typedef struct packed {
    logic load_box;
    logic plot;
    logic square;
    logic setup;
    logic xdyn;
    logic fix_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic fix_cond;
  } stat_t;

endpackage

// ===== design/ellipse_outline_stepper.sv =====
// top level of the ellipse outline stepper: controller plus datapath
//
// input channel (in_valid/in_ready): in_func = 0 starts an ellipse from the box
// fields, in_func = 1 asks for the next outline pixel. result channel
// (out_valid/out_ready): one transaction per input transaction, carrying the
// move taken, the pixel after the item and a done flag.
// a plot transaction is computed in the cycle it is accepted and its result is
// registered, so it shows on the output the next cycle; plots run one per
// cycle while the receiver keeps up.
// a start transaction passes through the states SQ, SETUP, XDYN, FIX and EMIT
// before its result is registered, with k leftward correction moves in FIX
// (k at most 2^COORD_BITS), one move per cycle in the correction loop; no input
// is taken meanwhile.
// when the receiver stalls, the result register holds its transaction and
// in_ready stays low until it is taken (a new item is taken in the same cycle
// the waiting result leaves).
// after reset no result is pending, the outline counts as finished and the
// pixel is 0,0: plots give done_res = 1 until a start arrives.
module ellipse_outline_stepper #(
  parameter int COORD_BITS = eos_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_func,
  input  logic signed [COORD_BITS-1:0] in_box_left,
  input  logic signed [COORD_BITS-1:0] in_box_top,
  input  logic signed [COORD_BITS-1:0] in_box_right,
  input  logic signed [COORD_BITS-1:0] in_box_bottom,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [1:0]            out_move_x,
  output logic signed [1:0]            out_move_y,
  output logic signed [COORD_BITS-1:0] out_pixel_x,
  output logic signed [COORD_BITS-1:0] out_pixel_y,
  output logic                         out_done_res
);

  eos_pkg::cmd_t  cmd;
  eos_pkg::stat_t stat;

  eos_ctrl #(
    .COORD_BITS(COORD_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  eos_dp #(
    .COORD_BITS(COORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .box_left   (in_box_left),
    .box_top    (in_box_top),
    .box_right  (in_box_right),
    .box_bottom (in_box_bottom),
    .move_x     (out_move_x),
    .move_y     (out_move_y),
    .pixel_x    (out_pixel_x),
    .pixel_y    (out_pixel_y),
    .done_res   (out_done_res)
  );

endmodule

// ===== design/eos_ctrl.sv =====
// controller: transaction handshakes, start setup sequence and correction loop count
module eos_ctrl #(
  parameter int COORD_BITS = eos_pkg::COORD_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_func,
  output logic           in_ready,
  input  logic           out_ready,
  output logic           out_valid,
  output eos_pkg::cmd_t  cmd,
  input  eos_pkg::stat_t stat
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SQ    = 6'b000010,
    ST_SETUP = 6'b000100,
    ST_XDYN  = 6'b001000,
    ST_FIX   = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t                state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [COORD_BITS:0]   cnt_r, cnt_nxt;
  logic                  out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = out_free;
        if (in_valid && out_free) begin
          if (in_func) begin
            cmd.plot = 1'b1;
          end else begin
            cmd.load_box = 1'b1;
            state_nxt    = ST_SQ;
          end
        end
      end
      ST_SQ: begin
        cmd.square = 1'b1;
        state_nxt  = ST_SETUP;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_XDYN;
      end
      ST_XDYN: begin
        cmd.xdyn  = 1'b1;
        state_nxt = ST_FIX;
      end
      ST_FIX: begin
        if (stat.fix_cond && !cnt_r[COORD_BITS]) begin
          cmd.fix_step = 1'b1;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.plot || cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.xdyn) begin
      cnt_nxt = '0;
    end else if (cmd.fix_step) begin
      cnt_nxt = cnt_r + (COORD_BITS + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

endmodule

// ===== design/eos_dp.sv =====
// datapath: box setup, error and cost registers, step logic and result register
module eos_dp #(
  parameter int COORD_BITS = eos_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  eos_pkg::cmd_t                cmd,
  output eos_pkg::stat_t               stat,
  input  logic signed [COORD_BITS-1:0] box_left,
  input  logic signed [COORD_BITS-1:0] box_top,
  input  logic signed [COORD_BITS-1:0] box_right,
  input  logic signed [COORD_BITS-1:0] box_bottom,
  output logic signed [1:0]            move_x,
  output logic signed [1:0]            move_y,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic                         done_res
);

  localparam int CB = COORD_BITS;
  localparam int SB = 2 * CB;
  localparam int DB = 3 * CB + 4;
  localparam int EB = ((4 * CB + 8) > 60) ? 60 : (4 * CB + 8);

  localparam logic [2:0] QUAD_0    = 3'd0;
  localparam logic [2:0] QUAD_1    = 3'd1;
  localparam logic [2:0] QUAD_2    = 3'd2;
  localparam logic [2:0] QUAD_3    = 3'd3;
  localparam logic [2:0] QUAD_DONE = 3'd4;

  localparam logic [1:0] OY_ZERO = 2'd0;
  localparam logic [1:0] OY_ONE  = 2'd1;
  localparam logic [1:0] OY_TWO  = 2'd2;

  localparam logic signed [1:0] MOVE_NONE = 2'sb00;
  localparam logic signed [1:0] MOVE_POS  = 2'sb01;
  localparam logic signed [1:0] MOVE_NEG  = 2'sb11;

  function automatic logic signed [DB+1:0] axis_cost(input logic signed [DB-1:0] dyn,
                                                     input logic [SB-1:0] stat_c,
                                                     input logic pos);
    logic signed [DB+1:0] d_e;
    logic signed [DB+1:0] s_e;
    d_e = (DB + 2)'(dyn);
    s_e = $signed((DB + 2)'(stat_c));
    axis_cost = pos ? (d_e + s_e) : (s_e - d_e);
  endfunction

  function automatic logic signed [DB-1:0] dyn_step(input logic signed [DB-1:0] dyn,
                                                    input logic [SB-1:0] stat_c,
                                                    input logic pos);
    logic signed [DB-1:0] inc;
    inc = $signed(DB'({stat_c, 1'b0}));
    dyn_step = pos ? (dyn + inc) : (dyn - inc);
  endfunction

  // state
  logic [2:0]             quad_r, quad_nxt;
  logic signed [CB-1:0]   cur_x_r, cur_x_nxt;
  logic signed [CB-1:0]   cur_y_r, cur_y_nxt;
  logic signed [EB-1:0]   err_r, err_nxt;
  logic signed [DB-1:0]   xd_r, xd_nxt;
  logic signed [DB-1:0]   yd_r, yd_nxt;
  logic [SB-1:0]          xs_r;
  logic [SB-1:0]          ys_r;

  // setup registers
  logic signed [CB:0]     dx_r, dy_r;
  logic [1:0]             oy_r;
  logic [2*CB:0]          dxsq_r, dysq_r;

  // result register
  logic signed [1:0]      mv_x_r, mv_y_r;
  logic signed [CB-1:0]   pix_x_r, pix_y_r;
  logic                   done_r;

  // box setup
  logic signed [CB:0]     l_e, t_e, r_e, b_e;
  logic signed [CB:0]     dx_w, dy_w, sum_tb, half_tb;
  logic [1:0]             oy_w;
  logic signed [CB-1:0]   px_w;
  logic signed [2*CB+1:0] dxsq_full, dysq_full;
  logic [EB+1:0]          csq_w, err_sum_w;
  logic signed [DB-1:0]   yd_setup;
  logic signed [3*CB+1:0] xd_prod;

  assign l_e     = (CB + 1)'(box_left);
  assign t_e     = (CB + 1)'(box_top);
  assign r_e     = (CB + 1)'(box_right);
  assign b_e     = (CB + 1)'(box_bottom);
  assign dx_w    = r_e - l_e - (CB + 1)'(1);
  assign dy_w    = b_e - t_e - (CB + 1)'(1);
  assign sum_tb  = t_e + b_e;
  // halve toward zero
  assign half_tb = (sum_tb + $signed({{CB{1'b0}}, sum_tb[CB]})) >>> 1;
  assign px_w    = box_right - CB'(1);

  always_comb begin
    if (!sum_tb[0]) begin
      oy_w = OY_ONE;
    end else if (sum_tb[CB]) begin
      oy_w = OY_TWO;
    end else begin
      oy_w = OY_ZERO;
    end
  end

  assign dxsq_full = dx_r * dx_r;
  assign dysq_full = dy_r * dy_r;

  always_comb begin
    case (oy_r)
      OY_ONE: begin
        csq_w    = (EB + 2)'(dxsq_r);
        yd_setup = $signed(DB'(dxsq_r[SB-1:0]));
      end
      OY_TWO: begin
        csq_w    = (EB + 2)'({dxsq_r, 2'b00});
        yd_setup = $signed(DB'({dxsq_r[SB-1:0], 1'b0}));
      end
      default: begin
        csq_w    = '0;
        yd_setup = '0;
      end
    endcase
  end

  assign err_sum_w = csq_w + (EB + 2)'(3);
  assign xd_prod   = dx_r * $signed({1'b0, xs_r});

  // leftward start correction
  logic signed [EB:0]   fix_diff;
  assign fix_diff      = (EB + 1)'(xd_r) - $signed((EB + 1)'(xs_r));
  assign stat.fix_cond = fix_diff <= (EB + 1)'(err_r);

  // plot step
  logic [1:0]           qd;
  logic                 active, sx_pos, sy_pos, prim_y;
  logic signed [DB+1:0] xc, yc, cp, co, c1, c2;
  logic signed [DB+2:0] tot;
  logic                 tot_neg, second, prim_mv, oth_mv, x_mv, y_mv;
  logic signed [EB-1:0] err1, err2;
  logic signed [EB:0]   chk;
  logic signed [DB-1:0] xd_pl, yd_pl;
  logic signed [CB-1:0] cur_x_pl, cur_y_pl;
  logic [2:0]           quad_pl;

  assign qd      = quad_r[1:0];
  assign active  = !quad_r[2];
  assign sx_pos  = qd[1];
  assign sy_pos  = (qd[1] == qd[0]);
  assign prim_y  = !qd[0];
  assign xc      = axis_cost(xd_r, xs_r, sx_pos);
  assign yc      = axis_cost(yd_r, ys_r, sy_pos);
  assign tot     = (DB + 3)'(xc) + (DB + 3)'(yc);
  assign tot_neg = tot[DB+2];
  assign cp      = prim_y ? yc : xc;
  assign co      = prim_y ? xc : yc;
  assign c1      = tot_neg ? cp : co;
  assign c2      = tot_neg ? co : cp;
  assign err1    = err_r + EB'(c1);
  assign chk     = (EB + 1)'(err1) + (EB + 1)'(co);
  assign second  = tot_neg ? !chk[EB] : err1[EB-1];
  assign err2    = second ? (err1 + EB'(c2)) : err1;
  assign prim_mv = tot_neg || second;
  assign oth_mv  = !tot_neg || second;
  assign x_mv    = prim_y ? oth_mv : prim_mv;
  assign y_mv    = prim_y ? prim_mv : oth_mv;
  assign xd_pl   = x_mv ? dyn_step(xd_r, xs_r, sx_pos) : xd_r;
  assign yd_pl   = y_mv ? dyn_step(yd_r, ys_r, sy_pos) : yd_r;

  always_comb begin
    cur_x_pl = cur_x_r;
    cur_y_pl = cur_y_r;
    if (x_mv) begin
      cur_x_pl = sx_pos ? (cur_x_r + CB'(1)) : (cur_x_r - CB'(1));
    end
    if (y_mv) begin
      cur_y_pl = sy_pos ? (cur_y_r + CB'(1)) : (cur_y_r - CB'(1));
    end
  end

  always_comb begin
    quad_pl = quad_r;
    case (quad_r)
      QUAD_0: begin
        if (xd_pl[DB-1] || xd_pl == '0) begin
          quad_pl = QUAD_1;
        end
      end
      QUAD_1: begin
        if (yd_pl[DB-1] || yd_pl == '0) begin
          quad_pl = QUAD_2;
        end
      end
      QUAD_2: begin
        if (!xd_pl[DB-1]) begin
          quad_pl = QUAD_3;
        end
      end
      QUAD_3: begin
        if (!yd_pl[DB-1]) begin
          quad_pl = QUAD_DONE;
        end
      end
      default: begin
        quad_pl = quad_r;
      end
    endcase
  end

  always_comb begin
    quad_nxt  = quad_r;
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    err_nxt   = err_r;
    xd_nxt    = xd_r;
    yd_nxt    = yd_r;
    if (cmd.load_box) begin
      quad_nxt  = QUAD_0;
      cur_x_nxt = px_w;
      cur_y_nxt = half_tb[CB-1:0];
    end
    if (cmd.setup) begin
      err_nxt = $signed(err_sum_w[EB+1:2]);
      yd_nxt  = yd_setup;
    end
    if (cmd.xdyn) begin
      xd_nxt = DB'(xd_prod);
    end
    if (cmd.fix_step) begin
      err_nxt   = err_r + EB'(axis_cost(xd_r, xs_r, 1'b0));
      xd_nxt    = dyn_step(xd_r, xs_r, 1'b0);
      cur_x_nxt = cur_x_r - CB'(1);
    end
    if (cmd.plot && active) begin
      quad_nxt  = quad_pl;
      cur_x_nxt = cur_x_pl;
      cur_y_nxt = cur_y_pl;
      err_nxt   = err2;
      xd_nxt    = xd_pl;
      yd_nxt    = yd_pl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quad_r  <= QUAD_DONE;
      cur_x_r <= '0;
      cur_y_r <= '0;
    end else begin
      quad_r  <= quad_nxt;
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r <= err_nxt;
    xd_r  <= xd_nxt;
    yd_r  <= yd_nxt;
    if (cmd.load_box) begin
      dx_r <= dx_w;
      dy_r <= dy_w;
      oy_r <= oy_w;
    end
    if (cmd.square) begin
      dxsq_r <= dxsq_full[2*CB:0];
      dysq_r <= dysq_full[2*CB:0];
    end
    if (cmd.setup) begin
      xs_r <= dysq_r[SB-1:0];
      ys_r <= dxsq_r[SB-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.plot) begin
      mv_x_r  <= (active && x_mv) ? (sx_pos ? MOVE_POS : MOVE_NEG) : MOVE_NONE;
      mv_y_r  <= (active && y_mv) ? (sy_pos ? MOVE_POS : MOVE_NEG) : MOVE_NONE;
      pix_x_r <= cur_x_nxt;
      pix_y_r <= cur_y_nxt;
      done_r  <= !active;
    end else if (cmd.emit) begin
      mv_x_r  <= MOVE_NONE;
      mv_y_r  <= MOVE_NONE;
      pix_x_r <= cur_x_r;
      pix_y_r <= cur_y_r;
      done_r  <= 1'b0;
    end
  end

  assign move_x   = mv_x_r;
  assign move_y   = mv_y_r;
  assign pixel_x  = pix_x_r;
  assign pixel_y  = pix_y_r;
  assign done_res = done_r;

endmodule
